// ===== hdl/htfc_pkg.sv =====
// ============================================================================
// htfc_pkg
// Shared types and constants for the heater thermostat fault controller.
// ============================================================================
package htfc_pkg;

    // Default widths for internal temperature and timer storage
    localparam int TEMP_BITS_DEF  = 16;
    localparam int TIMER_BITS_DEF = 20;

    // Configuration port geometry
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    // Register field widths
    localparam int ID_W  = 64;
    localparam int SP_W  = 11;
    localparam int HYS_W = 9;
    localparam int TO_W  = 20;

    // Register reset values
    localparam logic [SP_W-1:0]  SET_POINT_RST = SP_W'(608);
    localparam logic [HYS_W-1:0] HYST_RST      = HYS_W'(16);
    localparam logic [TO_W-1:0]  SCAN_TO_RST   = TO_W'(3 * 1000 * 60);
    localparam logic [TO_W-1:0]  READ_TO_RST   = TO_W'(10 * 1000);

    // Sensor slots and watch timers
    localparam int SLOT_AMB    = 0;
    localparam int SLOT_INLET  = 1;
    localparam int SLOT_OUTLET = 2;
    localparam int N_SLOTS     = 3;

    localparam int TMR_SCAN   = 0;
    localparam int TMR_AMB    = 1;
    localparam int TMR_INLET  = 2;
    localparam int TMR_OUTLET = 3;
    localparam int N_TIMERS   = 4;

    typedef enum logic [2:0] {
        REG_AMBIENT_ID = 3'd0,
        REG_INLET_ID   = 3'd1,
        REG_OUTLET_ID  = 3'd2,
        REG_SET_POINT  = 3'd3,
        REG_HYSTERESIS = 3'd4,
        REG_SCAN_TO    = 3'd5,
        REG_READ_TO    = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_START    = 3'd1,
        OP_STOP     = 3'd2,
        OP_RESET    = 3'd3,
        OP_READING  = 3'd4,
        OP_SCAN_END = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_HALTED  = 2'd0,
        ST_RUNNING = 2'd1,
        ST_FAULTED = 2'd2
    } ctrl_state_t;

    typedef enum logic [1:0] {
        FLT_NONE  = 2'd0,
        FLT_SCAN  = 2'd1,
        FLT_INLET = 2'd2
    } fault_t;

    typedef struct packed {
        logic [ID_W-1:0]  ambient_id;
        logic [ID_W-1:0]  inlet_id;
        logic [ID_W-1:0]  outlet_id;
        logic [SP_W-1:0]  set_point;
        logic [HYS_W-1:0] hysteresis;
        logic [TO_W-1:0]  scan_timeout;
        logic [TO_W-1:0]  read_timeout;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic [63:0]        sensor_id;
        logic signed [15:0] temperature;
    } req_t;

    typedef struct packed {
        logic               heater_on;
        logic [1:0]         controller_state;
        logic [1:0]         fault_reason;
        logic signed [15:0] ambient_temp;
        logic signed [15:0] inlet_temp;
        logic signed [15:0] outlet_temp;
        logic [31:0]        change_count;
        logic               outlet_stale;
        logic               ambient_stale;
        logic               unknown_sensor;
        logic               command_taken;
    } rsp_t;

endpackage

// ===== hdl/htfc_cfg.sv =====
// ============================================================================
// htfc_cfg
// Configuration register file behind the APB-style port.
// ============================================================================
module htfc_cfg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [htfc_pkg::ADDR_W-1:0]  paddr,
    input  logic [htfc_pkg::DATA_W-1:0]  pwdata,
    output logic [htfc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output htfc_pkg::cfg_t               cfg
);
    import htfc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    // registers sit on 8-byte boundaries
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_AMBIENT_ID: cfg_next.ambient_id   = ID_W'(pwdata);
                REG_INLET_ID:   cfg_next.inlet_id     = ID_W'(pwdata);
                REG_OUTLET_ID:  cfg_next.outlet_id    = ID_W'(pwdata);
                REG_SET_POINT:  cfg_next.set_point    = SP_W'(pwdata);
                REG_HYSTERESIS: cfg_next.hysteresis   = HYS_W'(pwdata);
                REG_SCAN_TO:    cfg_next.scan_timeout = TO_W'(pwdata);
                REG_READ_TO:    cfg_next.read_timeout = TO_W'(pwdata);
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_AMBIENT_ID: prdata = DATA_W'(cfg_reg.ambient_id);
            REG_INLET_ID:   prdata = DATA_W'(cfg_reg.inlet_id);
            REG_OUTLET_ID:  prdata = DATA_W'(cfg_reg.outlet_id);
            REG_SET_POINT:  prdata = DATA_W'(cfg_reg.set_point);
            REG_HYSTERESIS: prdata = DATA_W'(cfg_reg.hysteresis);
            REG_SCAN_TO:    prdata = DATA_W'(cfg_reg.scan_timeout);
            REG_READ_TO:    prdata = DATA_W'(cfg_reg.read_timeout);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ambient_id   <= '0;
            cfg_reg.inlet_id     <= '0;
            cfg_reg.outlet_id    <= '0;
            cfg_reg.set_point    <= SET_POINT_RST;
            cfg_reg.hysteresis   <= HYST_RST;
            cfg_reg.scan_timeout <= SCAN_TO_RST;
            cfg_reg.read_timeout <= READ_TO_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/htfc_core.sv =====
// ============================================================================
// htfc_core
// Request register, single-pass controller update and response register.
// ============================================================================
module htfc_core
#(
    parameter int TEMP_BITS  = htfc_pkg::TEMP_BITS_DEF,
    parameter int TIMER_BITS = htfc_pkg::TIMER_BITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  htfc_pkg::cfg_t cfg,
    input  logic           req_valid,
    output logic           req_ready,
    input  htfc_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output htfc_pkg::rsp_t rsp_data
);
    import htfc_pkg::*;

    // saturation of incoming readings to TEMP_BITS
    localparam int SAT_W = ((TEMP_BITS > 16) ? TEMP_BITS : 16) + 1;
    localparam logic signed [SAT_W-1:0] T_HI =
        signed'((SAT_W'(1) << (TEMP_BITS - 1)) - SAT_W'(1));
    localparam logic signed [SAT_W-1:0] T_LO = -T_HI - SAT_W'(1);
    // band limits need room for set point plus hysteresis
    localparam int CMP_W = TEMP_BITS + 2;
    localparam logic [32:0] TMR_MAX = (33'd1 << TIMER_BITS) - 33'd1;

    typedef logic [TEMP_BITS-1:0]  temp_t;
    typedef logic [TIMER_BITS-1:0] tmr_t;

    // request stage
    logic  req_vld_reg;
    req_t  req_reg;
    logic  adv;

    // controller state
    ctrl_state_t state_reg, state_next;
    fault_t      fault_reg, fault_next;
    logic        heater_reg, heater_next;
    logic        read_once_reg, read_once_next;
    temp_t       committed_reg [N_SLOTS];
    temp_t       committed_next [N_SLOTS];
    temp_t       pending_reg [N_SLOTS];
    temp_t       pending_next [N_SLOTS];
    logic [N_SLOTS-1:0] pvalid_reg, pvalid_next;
    tmr_t        timer_reg [N_TIMERS];
    tmr_t        timer_next [N_TIMERS];
    logic [31:0] seq_reg, seq_next;

    // response stage
    logic  rsp_vld_reg;
    rsp_t  rsp_reg, rsp_next;

    logic  taken, unknown, evaluate, changed, ostale, astale;
    tmr_t  scan_load, read_load;
    temp_t rd_temp;
    logic signed [SAT_W-1:0] rd_wide;
    logic signed [CMP_W-1:0] off_lim, on_lim, inlet_w;

    assign adv       = req_vld_reg && (!rsp_vld_reg || rsp_ready);
    assign req_ready = !req_vld_reg || adv;
    assign rsp_valid = rsp_vld_reg;
    assign rsp_data  = rsp_reg;

    // reload values saturate to the timer range
    assign scan_load = (33'(cfg.scan_timeout) > TMR_MAX) ? TIMER_BITS'(TMR_MAX)
                                                         : TIMER_BITS'(cfg.scan_timeout);
    assign read_load = (33'(cfg.read_timeout) > TMR_MAX) ? TIMER_BITS'(TMR_MAX)
                                                         : TIMER_BITS'(cfg.read_timeout);

    always_comb
    begin
        rd_wide = SAT_W'(req_reg.temperature);
        if (rd_wide > T_HI)
            rd_temp = TEMP_BITS'(T_HI);
        else if (rd_wide < T_LO)
            rd_temp = TEMP_BITS'(T_LO);
        else
            rd_temp = TEMP_BITS'(rd_wide);
    end

    assign off_lim = signed'(CMP_W'(cfg.set_point)) + signed'(CMP_W'(cfg.hysteresis));
    assign on_lim  = signed'(CMP_W'(cfg.set_point)) - signed'(CMP_W'(cfg.hysteresis));

    always_comb
    begin
        state_next     = state_reg;
        fault_next     = fault_reg;
        heater_next    = heater_reg;
        read_once_next = read_once_reg;
        committed_next = committed_reg;
        pending_next   = pending_reg;
        pvalid_next    = pvalid_reg;
        timer_next     = timer_reg;
        taken          = 1'b0;
        unknown        = 1'b0;
        evaluate       = 1'b1;
        changed        = 1'b0;
        ostale         = 1'b0;
        astale         = 1'b0;
        inlet_w        = '0;

        if (req_reg.operation == OP_START && state_reg == ST_HALTED)
        begin
            taken          = 1'b1;
            evaluate       = 1'b0;
            state_next     = ST_RUNNING;
            read_once_next = 1'b0;
            timer_next[TMR_SCAN] = scan_load;
            for (int i = 0; i < N_SLOTS; i++)
            begin
                timer_next[i+1] = read_load;
                pending_next[i] = '0;
            end
            pvalid_next = '0;
        end
        else if (req_reg.operation == OP_STOP && state_reg == ST_RUNNING)
        begin
            taken       = 1'b1;
            evaluate    = 1'b0;
            heater_next = 1'b0;
            state_next  = ST_HALTED;
        end
        else if (req_reg.operation == OP_RESET && state_reg == ST_FAULTED)
        begin
            taken      = 1'b1;
            evaluate   = 1'b0;
            state_next = ST_HALTED;
        end
        else if (state_reg == ST_RUNNING)
        begin
            case (req_reg.operation)
                OP_TICK:
                begin
                    for (int i = 0; i < N_TIMERS; i++)
                    begin
                        if (timer_reg[i] != '0)
                            timer_next[i] = timer_reg[i] - TIMER_BITS'(1);
                    end
                end
                OP_READING:
                begin
                    // first match wins when IDs collide
                    if (req_reg.sensor_id == cfg.ambient_id)
                    begin
                        pending_next[SLOT_AMB] = rd_temp;
                        pvalid_next[SLOT_AMB]  = 1'b1;
                    end
                    else if (req_reg.sensor_id == cfg.inlet_id)
                    begin
                        pending_next[SLOT_INLET] = rd_temp;
                        pvalid_next[SLOT_INLET]  = 1'b1;
                    end
                    else if (req_reg.sensor_id == cfg.outlet_id)
                    begin
                        pending_next[SLOT_OUTLET] = rd_temp;
                        pvalid_next[SLOT_OUTLET]  = 1'b1;
                    end
                    else
                    begin
                        unknown = 1'b1;
                    end
                end
                OP_SCAN_END:
                begin
                    read_once_next       = 1'b1;
                    timer_next[TMR_SCAN] = scan_load;
                    for (int i = 0; i < N_SLOTS; i++)
                    begin
                        if (pvalid_reg[i])
                        begin
                            if (committed_reg[i] != pending_reg[i])
                                changed = 1'b1;
                            committed_next[i] = pending_reg[i];
                            timer_next[i+1]   = read_load;
                            pvalid_next[i]    = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (evaluate && state_reg == ST_RUNNING)
        begin
            if (timer_next[TMR_SCAN] == '0)
            begin
                heater_next = 1'b0;
                fault_next  = FLT_SCAN;
                state_next  = ST_FAULTED;
            end
            else if (timer_next[TMR_INLET] == '0)
            begin
                heater_next = 1'b0;
                fault_next  = FLT_INLET;
                state_next  = ST_FAULTED;
            end
            else
            begin
                ostale = (timer_next[TMR_OUTLET] == '0);
                astale = (timer_next[TMR_AMB] == '0);
                inlet_w = CMP_W'(signed'(committed_next[SLOT_INLET]));
                if (!read_once_next)
                    heater_next = 1'b0;
                else if (inlet_w > off_lim)
                    heater_next = 1'b0;
                else if (inlet_w < on_lim)
                    heater_next = 1'b1;
            end
        end

        seq_next = seq_reg + 32'(changed) + 32'(heater_next != heater_reg);

        rsp_next.heater_on        = heater_next;
        rsp_next.controller_state = state_next;
        rsp_next.fault_reason     = fault_next;
        rsp_next.ambient_temp     = 16'(signed'(committed_next[SLOT_AMB]));
        rsp_next.inlet_temp       = 16'(signed'(committed_next[SLOT_INLET]));
        rsp_next.outlet_temp      = 16'(signed'(committed_next[SLOT_OUTLET]));
        rsp_next.change_count     = seq_next;
        rsp_next.outlet_stale     = ostale;
        rsp_next.ambient_stale    = astale;
        rsp_next.unknown_sensor   = unknown;
        rsp_next.command_taken    = taken;
    end

    // handshake stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
                req_vld_reg <= req_valid;
            if (adv)
                rsp_vld_reg <= 1'b1;
            else if (rsp_ready)
                rsp_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
            req_reg <= req_data;
        if (adv)
            rsp_reg <= rsp_next;
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HALTED;
            fault_reg     <= FLT_NONE;
            heater_reg    <= 1'b0;
            read_once_reg <= 1'b0;
            pvalid_reg    <= '0;
            seq_reg       <= 32'd1;
            for (int i = 0; i < N_SLOTS; i++)
            begin
                committed_reg[i] <= '0;
                pending_reg[i]   <= '0;
            end
            for (int i = 0; i < N_TIMERS; i++)
                timer_reg[i] <= '0;
        end
        else if (adv)
        begin
            state_reg     <= state_next;
            fault_reg     <= fault_next;
            heater_reg    <= heater_next;
            read_once_reg <= read_once_next;
            pvalid_reg    <= pvalid_next;
            seq_reg       <= seq_next;
            committed_reg <= committed_next;
            pending_reg   <= pending_next;
            timer_reg     <= timer_next;
        end
    end

    a_fault_has_reason: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FAULTED |-> fault_reg != FLT_NONE)
        else $error("faulted without a fault reason");

    a_heater_only_running: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_RUNNING |-> !heater_reg)
        else $error("heater on outside running state");

    a_heater_needs_scan: assert property (@(posedge clk) disable iff (!rst_n)
        !read_once_reg |-> !heater_reg)
        else $error("heater on before first committed scan");

    a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(state_reg) && $stable(seq_reg) && $stable(heater_reg))
        else $error("controller state moved without a request");

    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> (seq_reg - $past(seq_reg)) <= 32'd2)
        else $error("sequence count jumped by more than two");

endmodule

// ===== hdl/heater_thermostat_fault_controller_unit.sv =====
// ============================================================================
// heater_thermostat_fault_controller_unit
// Hysteresis thermostat with scan and sensor watchdogs behind an APB-style port.
// ============================================================================
// The request is captured in the request register; the whole update is one pass
// between it and the response register, which drives rsp_valid and rsp_data.
// Throughput: one request per cycle while the response side is not stalled; a
// full response register is refilled in the same cycle it is taken.
// Reset (rst_n low, async): halted, heater off, no fault, temps zero, timers
// zero, change count one, registers at their defaults.
module heater_thermostat_fault_controller_unit
#(
    parameter int TEMP_BITS  = htfc_pkg::TEMP_BITS_DEF,
    parameter int TIMER_BITS = htfc_pkg::TIMER_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [htfc_pkg::ADDR_W-1:0]  paddr,
    input  logic [htfc_pkg::DATA_W-1:0]  pwdata,
    output logic [htfc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  htfc_pkg::req_t               req_data,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output htfc_pkg::rsp_t               rsp_data
);
    import htfc_pkg::*;

    cfg_t cfg;

    htfc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    htfc_core
    #(
        .TEMP_BITS  (TEMP_BITS),
        .TIMER_BITS (TIMER_BITS)
    )
    u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

// ===== tb/heater_thermostat_fault_controller_unit_tb.sv =====
// ============================================================================
// heater_thermostat_fault_controller_unit_tb
// Self-checking bench: drives commands, sensor readings, scan ends and ticks,
// and checks every response against an in-bench thermostat predictor.
// ============================================================================
`timescale 1ns / 100ps

module heater_thermostat_fault_controller_unit_tb;
    import htfc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              req_valid;
    logic              req_ready;
    req_t              req_data;
    logic              rsp_valid;
    logic              rsp_ready;
    rsp_t              rsp_data;

    heater_thermostat_fault_controller_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    // thermostat mirror: configuration
    logic [ID_W-1:0]  cfg_id [N_SLOTS];
    logic [SP_W-1:0]  cfg_sp;
    logic [HYS_W-1:0] cfg_hyst;
    logic [TO_W-1:0]  cfg_scan_to;
    logic [TO_W-1:0]  cfg_read_to;

    // thermostat mirror: state
    ctrl_state_t                    ctl_state;
    fault_t                         flt;
    logic                           heat_on;
    logic                           scanned;
    logic signed [15:0]             temp_now  [N_SLOTS];
    logic signed [15:0]             pend_temp [N_SLOTS];
    logic                           pend_ok   [N_SLOTS];
    logic [TIMER_BITS_DEF-1:0]      wd_timer  [N_TIMERS];
    logic [31:0]                    seq_count;

    rsp_t awaited_status[$];
    int   error_count = 0;
    int   items_sent  = 0;
    int   cycle_count = 0;
    int   hold_cycles = 0;
    int   stall_left  = 0;
    bit   send_idle   = 0;
    bit   recv_idle   = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("** heater_thermostat_fault_controller_unit: FAILED **");
            $finish;
        end
    end

    function automatic void thermostat_reset();
        int i;
        for (i = 0; i < N_SLOTS; i++)
        begin
            cfg_id[i]    = '0;
            temp_now[i]  = '0;
            pend_temp[i] = '0;
            pend_ok[i]   = 1'b0;
        end
        for (i = 0; i < N_TIMERS; i++)
            wd_timer[i] = '0;
        cfg_sp      = SET_POINT_RST;
        cfg_hyst    = HYST_RST;
        cfg_scan_to = SCAN_TO_RST;
        cfg_read_to = READ_TO_RST;
        ctl_state   = ST_HALTED;
        flt         = FLT_NONE;
        heat_on     = 1'b0;
        scanned     = 1'b0;
        seq_count   = 32'd1;
    endfunction

    function automatic void heater_set(logic on);
        if (on != heat_on)
        begin
            heat_on = on;
            seq_count++;
        end
    endfunction

    // Advances the mirror by one request and returns the status it should produce.
    function automatic rsp_t step_thermostat(req_t r);
        rsp_t o;
        logic taken, unknown, run_eval, ostale, astale, changed;
        int   slot, off_lim, on_lim, i;
        taken    = 1'b0;
        unknown  = 1'b0;
        run_eval = 1'b1;
        ostale   = 1'b0;
        astale   = 1'b0;
        changed  = 1'b0;
        slot     = -1;
        if (r.operation == OP_START && ctl_state == ST_HALTED)
        begin
            taken     = 1'b1;
            run_eval  = 1'b0;
            ctl_state = ST_RUNNING;
            scanned   = 1'b0;
            wd_timer[TMR_SCAN] = cfg_scan_to;
            for (i = 0; i < N_SLOTS; i++)
            begin
                wd_timer[i + 1] = cfg_read_to;
                pend_ok[i]      = 1'b0;
                pend_temp[i]    = '0;
            end
        end
        else if (r.operation == OP_STOP && ctl_state == ST_RUNNING)
        begin
            taken    = 1'b1;
            run_eval = 1'b0;
            heater_set(1'b0);
            ctl_state = ST_HALTED;
        end
        else if (r.operation == OP_RESET && ctl_state == ST_FAULTED)
        begin
            taken     = 1'b1;
            run_eval  = 1'b0;
            ctl_state = ST_HALTED;
        end
        else if (ctl_state == ST_RUNNING)
        begin
            case (r.operation)
                OP_TICK:
                begin
                    for (i = 0; i < N_TIMERS; i++)
                        if (wd_timer[i] != 0)
                            wd_timer[i]--;
                end
                OP_READING:
                begin
                    // ambient wins over inlet, inlet over outlet on shared IDs
                    if (r.sensor_id == cfg_id[SLOT_AMB])
                        slot = SLOT_AMB;
                    else if (r.sensor_id == cfg_id[SLOT_INLET])
                        slot = SLOT_INLET;
                    else if (r.sensor_id == cfg_id[SLOT_OUTLET])
                        slot = SLOT_OUTLET;
                    if (slot < 0)
                        unknown = 1'b1;
                    else
                    begin
                        pend_temp[slot] = r.temperature;
                        pend_ok[slot]   = 1'b1;
                    end
                end
                OP_SCAN_END:
                begin
                    scanned = 1'b1;
                    wd_timer[TMR_SCAN] = cfg_scan_to;
                    for (i = 0; i < N_SLOTS; i++)
                    begin
                        if (pend_ok[i])
                        begin
                            if (temp_now[i] != pend_temp[i])
                                changed = 1'b1;
                            temp_now[i]     = pend_temp[i];
                            wd_timer[i + 1] = cfg_read_to;
                            pend_ok[i]      = 1'b0;
                        end
                    end
                    if (changed)
                        seq_count++;
                end
                default: ;
            endcase
        end

        if (run_eval && ctl_state == ST_RUNNING)
        begin
            if (wd_timer[TMR_SCAN] == 0)
            begin
                heater_set(1'b0);
                flt       = FLT_SCAN;
                ctl_state = ST_FAULTED;
            end
            else if (wd_timer[TMR_INLET] == 0)
            begin
                heater_set(1'b0);
                flt       = FLT_INLET;
                ctl_state = ST_FAULTED;
            end
            else
            begin
                ostale = (wd_timer[TMR_OUTLET] == 0);
                astale = (wd_timer[TMR_AMB] == 0);
                if (!scanned)
                    heater_set(1'b0);
                else
                begin
                    off_lim = int'(cfg_sp) + int'(cfg_hyst);
                    on_lim  = int'(cfg_sp) - int'(cfg_hyst);
                    if (int'(temp_now[SLOT_INLET]) > off_lim)
                        heater_set(1'b0);
                    else if (int'(temp_now[SLOT_INLET]) < on_lim)
                        heater_set(1'b1);
                end
            end
        end

        o.heater_on        = heat_on;
        o.controller_state = ctl_state;
        o.fault_reason     = flt;
        o.ambient_temp     = temp_now[SLOT_AMB];
        o.inlet_temp       = temp_now[SLOT_INLET];
        o.outlet_temp      = temp_now[SLOT_OUTLET];
        o.change_count     = seq_count;
        o.outlet_stale     = ostale;
        o.ambient_stale    = astale;
        o.unknown_sensor   = unknown;
        o.command_taken    = taken;
        return o;
    endfunction

    function automatic int pick_gap();
        int r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : status_check
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_status.size() == 0)
            begin
                $display("%0t: response with no request outstanding: expected none, actual %p",
                         $time, rsp_data);
                error_count++;
            end
            else
            begin
                want = awaited_status.pop_front();
                check_field("heater_on", want.heater_on, rsp_data.heater_on);
                check_field("controller_state", want.controller_state,
                            rsp_data.controller_state);
                check_field("fault_reason", want.fault_reason, rsp_data.fault_reason);
                check_field("ambient_temp", want.ambient_temp, rsp_data.ambient_temp);
                check_field("inlet_temp", want.inlet_temp, rsp_data.inlet_temp);
                check_field("outlet_temp", want.outlet_temp, rsp_data.outlet_temp);
                check_field("change_count", want.change_count, rsp_data.change_count);
                check_field("outlet_stale", want.outlet_stale, rsp_data.outlet_stale);
                check_field("ambient_stale", want.ambient_stale, rsp_data.ambient_stale);
                check_field("unknown_sensor", want.unknown_sensor, rsp_data.unknown_sensor);
                check_field("command_taken", want.command_taken, rsp_data.command_taken);
            end
        end
    end

    // response side: long hold-off first, then random stalls when enabled
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                rsp_ready <= 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                rsp_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if (recv_idle)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic send_request(logic [2:0] op, logic [63:0] id = '0, logic [15:0] temp = '0);
        req_t item;
        int   gap;
        item.operation   = op;
        item.sensor_id   = id;
        item.temperature = temp;
        gap = send_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= item;
        do @(posedge clk); while (!req_ready);
        awaited_status.insert(awaited_status.size(), step_thermostat(item));
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (awaited_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) * 8);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_AMBIENT_ID: cfg_id[SLOT_AMB]    = value;
            REG_INLET_ID:   cfg_id[SLOT_INLET]  = value;
            REG_OUTLET_ID:  cfg_id[SLOT_OUTLET] = value;
            REG_SET_POINT:  cfg_sp              = value[SP_W-1:0];
            REG_HYSTERESIS: cfg_hyst            = value[HYS_W-1:0];
            REG_SCAN_TO:    cfg_scan_to         = value[TO_W-1:0];
            REG_READ_TO:    cfg_read_to         = value[TO_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_config(logic [63:0] amb, logic [63:0] inl, logic [63:0] outl,
                                logic [63:0] sp, logic [63:0] hy,
                                logic [63:0] scan_to, logic [63:0] read_to);
        apb_write(REG_AMBIENT_ID, amb);
        apb_write(REG_INLET_ID, inl);
        apb_write(REG_OUTLET_ID, outl);
        apb_write(REG_SET_POINT, sp);
        apb_write(REG_HYSTERESIS, hy);
        apb_write(REG_SCAN_TO, scan_to);
        apb_write(REG_READ_TO, read_to);
    endtask

    function automatic logic [15:0] sample_temp(int s);
        int span;
        span = 2 * int'(cfg_hyst) + 4;
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        if (s == SLOT_INLET)
            return 16'(int'(cfg_sp) + int'($urandom_range(0, 2 * span)) - span);
        if ($urandom_range(0, 2) == 0)
            return temp_now[s];
        return 16'($urandom);
    endfunction

    // Mostly well-formed scan rounds, steered by the mirrored state.
    task automatic run_scan_traffic(int count);
        int          stop_at, pick, s;
        logic [63:0] id;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (ctl_state == ST_HALTED && pick < 85)
                send_request(OP_START);
            else if (ctl_state == ST_FAULTED && pick < 75)
                send_request(OP_RESET);
            else if (ctl_state == ST_RUNNING && pick < 70)
            begin
                for (s = 0; s < N_SLOTS; s++)
                begin
                    if ($urandom_range(0, 9) < ((s == SLOT_INLET) ? 9 : 7))
                    begin
                        send_request(OP_READING, cfg_id[s], sample_temp(s));
                        if ($urandom_range(0, 9) == 0)
                            send_request(OP_READING, cfg_id[s], sample_temp(s));
                    end
                end
                if ($urandom_range(0, 9) != 0)
                    send_request(OP_SCAN_END);
                repeat ($urandom_range(0, 3))
                    send_request(OP_TICK);
            end
            else if (ctl_state == ST_RUNNING && pick < 80)
                repeat ($urandom_range(1, 4))
                    send_request(OP_TICK);
            else if (ctl_state == ST_RUNNING && pick < 86)
                send_request(OP_STOP);
            else
            begin
                id = {$urandom, $urandom};
                if ($urandom_range(0, 1) == 0)
                    id = cfg_id[$urandom_range(0, N_SLOTS - 1)];
                send_request(3'($urandom_range(0, 7)), id, 16'($urandom));
            end
        end
    endtask

    task automatic test_command_gating();
        // default registers: every sensor ID is zero
        send_request(OP_STOP);
        send_request(OP_RESET);
        send_request(OP_READING, 64'h1, 16'h7FFF);
        send_request(OP_SCAN_END);
        send_request(OP_START);
        send_request(OP_START);
        send_request(OP_RESET);
        send_request(OP_READING, 64'h0, 16'h7FFF);   // shared ID lands on ambient
        send_request(OP_READING, 64'h1, 16'h8000);
        send_request(OP_SCAN_END);
        send_request(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        send_request(OP_STOP);
    endtask

    task automatic test_hysteresis_band();
        wait_idle();
        write_config(64'h0123_4567_89AB_CDEF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001,
                     800, 320, 20'hFFFFF, 20'hFFFFF);
        send_request(OP_START);
        send_request(OP_SCAN_END);                       // nothing pending, inlet 0: heat
        send_request(OP_READING, cfg_id[SLOT_INLET], 16'd1120);
        send_request(OP_SCAN_END);                       // upper edge: hold
        send_request(OP_READING, cfg_id[SLOT_INLET], 16'd1121);
        send_request(OP_SCAN_END);
        send_request(OP_READING, cfg_id[SLOT_INLET], 16'd480);
        send_request(OP_SCAN_END);                       // lower edge: hold
        send_request(OP_READING, cfg_id[SLOT_INLET], 16'd479);
        send_request(OP_SCAN_END);
        send_request(OP_READING, cfg_id[SLOT_INLET], 16'h8000);
        send_request(OP_READING, cfg_id[SLOT_INLET], 16'h7FFF);  // last one wins
        send_request(OP_READING, cfg_id[SLOT_AMB], 16'h8000);
        send_request(OP_READING, cfg_id[SLOT_OUTLET], 16'h7FFF);
        send_request(OP_SCAN_END);
        send_request(OP_STOP);
    endtask

    task automatic test_zero_timeouts();
        wait_idle();
        apb_write(REG_SCAN_TO, 0);
        send_request(OP_START);
        send_request(OP_TICK);
        send_request(OP_RESET);
        wait_idle();
        apb_write(REG_SCAN_TO, 5);
        apb_write(REG_READ_TO, 0);
        send_request(OP_START);
        send_request(OP_READING, cfg_id[SLOT_INLET], 16'd100);
        send_request(OP_RESET);
    endtask

    task automatic test_backpressure();
        wait_idle();
        apb_write(REG_SCAN_TO, 40);
        apb_write(REG_READ_TO, 30);
        send_idle   = 1'b0;
        recv_idle   = 1'b0;
        hold_cycles = 80;
        run_scan_traffic(40);
    endtask

    task automatic test_random_scans();
        int          phase;
        logic [63:0] amb, inl, outl;
        int          sp, hy, sto, rto;
        for (phase = 0; phase < 12; phase++)
        begin
            wait_idle();
            if (phase == 0)
                write_config('1, '1, '1, 2047, 511, 20'hFFFFF, 20'hFFFFF);
            else if (phase == 1)
                write_config('0, '0, '0, 0, 0, 0, 0);
            else
            begin
                amb  = {$urandom, $urandom};
                inl  = {$urandom, $urandom};
                outl = {$urandom, $urandom};
                if ($urandom_range(0, 6) == 0)
                    inl = amb;
                else if ($urandom_range(0, 6) == 0)
                    outl = inl;
                sp  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                  : $urandom_range(0, 2000);
                hy  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                  : $urandom_range(0, 320);
                rto = $urandom_range(1, 30);
                if ($urandom_range(0, 9) == 0)
                    sto = 20'hFFFFF;
                else if ($urandom_range(0, 3) == 0)
                    sto = rto;                        // tie: scan fault must win
                else
                    sto = $urandom_range(2, 40);
                write_config(amb, inl, outl, sp, hy, sto, rto);
            end
            send_idle = phase[0];
            recv_idle = phase[1];
            run_scan_traffic(130);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        req_valid = 1'b0;
        req_data  = '0;
        thermostat_reset();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_command_gating();
        test_hysteresis_band();
        test_zero_timeouts();
        test_backpressure();
        test_random_scans();

        wait_idle();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("** heater_thermostat_fault_controller_unit: PASSED **");
        else
            $display("** heater_thermostat_fault_controller_unit: FAILED **");
        $finish;
    end

endmodule
